FILE: hdl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  // operand width used by the datapath, and the fixed width of the ports
  localparam int Width = 32;
  localparam int DataW = 32;

  // operand selection for the shared modular multiplier
  typedef enum logic [1:0] {
    SEL_REDUCE,
    SEL_MULT,
    SEL_SQUARE
  } mul_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e sel;
    logic     wr_base;
    logic     wr_acc;
    logic     shift_exp;
    logic     load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/modular_exponentiation.sv
// modular exponentiation: power_result = base_value ^ exponent mod modulus
// input channel: in_valid_i / in_stall_o with base_value_i, exponent_i and
//   modulus_i; a transaction is taken when valid is high and stall is low.
//   stall is low only while the block is idle, so one item is worked at a time.
// output channel: out_valid_o / out_stall_i with power_result_o and
//   bad_modulus_o, held in an output register; a new item may be taken while
//   the previous result still waits there.
// work: the base is first reduced by the modulus, then the exponent is scanned
//   lsb first with a multiply on each set bit and a square on every bit.
//   every modular product runs on one shared shift-and-subtract multiplier
//   that handles one multiplier bit per cycle.
// a zero modulus gives result 0 with bad_modulus_o set; a zero exponent gives 1.
// if the receiver stalls, the result stays in the output register and the
//   finished next item waits in the controller until the register frees.
// reset (rst_ni low, asynchronous) returns to idle and drops out_valid_o.
`default_nettype none

module modular_exponentiation (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [mexp_pkg::DataW-1:0] base_value_i,
  input  wire logic [mexp_pkg::DataW-1:0] exponent_i,
  input  wire logic [mexp_pkg::DataW-1:0] modulus_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [mexp_pkg::DataW-1:0] power_result_o,
  output logic                            bad_modulus_o
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mexp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .modulus_i      (modulus_i),
    .power_result_o (power_result_o),
    .bad_modulus_o  (bad_modulus_o)
  );

endmodule

`default_nettype wire

FILE: hdl/mexp_mulmod.sv
`default_nettype none

// bit-serial interleaved modular multiplier: r = a * b mod m
// one bit of a per cycle, msb first; needs b <= m and m != 0
module mexp_mulmod (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mexp_pkg::Width-1:0] a_i,
  input  wire logic [mexp_pkg::Width-1:0] b_i,
  input  wire logic [mexp_pkg::Width-1:0] m_i,
  output logic                            done_o,
  output logic      [mexp_pkg::Width-1:0] r_o
);

  localparam int W    = mexp_pkg::Width;
  localparam int CntW = $clog2(W);

  logic [W-1:0]    a_q, b_q, m_q, r_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  logic [W:0]   dbl, sum, m_ext;
  logic [W-1:0] dbl_red, r_d;

  // double and reduce, then add b if the current bit of a is set and reduce
  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? W'(dbl - m_ext) : W'(dbl);
    sum     = {1'b0, dbl_red} + (a_q[W-1] ? {1'b0, b_q} : '0);
    r_d     = (sum >= m_ext) ? W'(sum - m_ext) : W'(sum);
  end

  // step sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      m_q    <= '0;
      r_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      m_q    <= m_i;
      r_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      r_q   <= r_d;
      a_q   <= a_q << 1;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

`ifndef NO_ASSERTIONS
  // a new product is never started over one in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("mulmod started while busy");
  // a finished product is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (r_q < m_q))
    else $error("mulmod result not reduced");
  // done follows the last step only
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("mulmod done without work");
`endif

endmodule

`default_nettype wire

FILE: hdl/mexp_dp.sv
`default_nettype none

module mexp_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mexp_pkg::cmd_t             cmd_i,
  output mexp_pkg::status_t               status_o,
  input  wire logic [mexp_pkg::DataW-1:0] base_value_i,
  input  wire logic [mexp_pkg::DataW-1:0] exponent_i,
  input  wire logic [mexp_pkg::DataW-1:0] modulus_i,
  output logic      [mexp_pkg::DataW-1:0] power_result_o,
  output logic                            bad_modulus_o
);

  localparam int W = mexp_pkg::Width;

  logic [W-1:0] base_q, exp_q, mod_q, acc_q, power_q;
  logic         bad_q;
  logic [W-1:0] mul_a, mul_b, mul_r;
  logic         mul_done;

  // operand selection for the multiplier
  always_comb begin
    unique case (cmd_i.sel)
      mexp_pkg::SEL_REDUCE: begin
        mul_a = base_q;
        mul_b = W'(1);
      end
      mexp_pkg::SEL_MULT: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      mexp_pkg::SEL_SQUARE: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = base_q;
        mul_b = base_q;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mod_q),
    .done_o  (mul_done),
    .r_o     (mul_r)
  );

  // operand, accumulator and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      exp_q   <= '0;
      mod_q   <= '0;
      acc_q   <= '0;
      power_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        base_q <= base_value_i[W-1:0];
        exp_q  <= exponent_i[W-1:0];
        mod_q  <= modulus_i[W-1:0];
        acc_q  <= W'(1);
      end
      if (cmd_i.wr_base) begin
        base_q <= mul_r;
      end
      if (cmd_i.wr_acc) begin
        acc_q <= mul_r;
      end
      if (cmd_i.shift_exp) begin
        exp_q <= exp_q >> 1;
      end
      if (cmd_i.load_out) begin
        power_q <= (mod_q == '0) ? '0 : acc_q;
        bad_q   <= (mod_q == '0);
      end
    end
  end

  assign status_o.mod_zero = (mod_q == '0);
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];
  assign status_o.mul_done = mul_done;

  assign power_result_o = mexp_pkg::DataW'(power_q);
  assign bad_modulus_o  = bad_q;

`ifndef NO_ASSERTIONS
  // a delivered result is reduced, or the unreduced one of a zero exponent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && (mod_q != '0)) |=> ((power_q < mod_q) || (power_q == W'(1))))
    else $error("result not reduced");
  // a zero modulus always gives a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && (mod_q == '0)) |=> (bad_q && (power_q == '0)))
    else $error("zero modulus result wrong");
  // base and accumulator are written only from a finished product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_base || cmd_i.wr_acc) |-> mul_done)
    else $error("write-back without a finished product");
`endif

endmodule

`default_nettype wire

FILE: hdl/mexp_ctrl.sv
`default_nettype none

module mexp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire mexp_pkg::status_t status_i,
  output mexp_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_REDUCE,
    ST_STEP,
    ST_MULT,
    ST_SQUARE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.sel   = mexp_pkg::SEL_REDUCE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (status_i.mod_zero || status_i.exp_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.sel       = mexp_pkg::SEL_REDUCE;
          state_d         = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status_i.mul_done) begin
          cmd_o.wr_base = 1'b1;
          state_d       = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status_i.exp_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.exp_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.sel       = mexp_pkg::SEL_MULT;
          state_d         = ST_MULT;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.sel       = mexp_pkg::SEL_SQUARE;
          state_d         = ST_SQUARE;
        end
      end
      ST_MULT: begin
        cmd_o.sel = mexp_pkg::SEL_MULT;
        if (status_i.mul_done) begin
          cmd_o.wr_acc    = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.sel       = mexp_pkg::SEL_SQUARE;
          state_d         = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.sel = mexp_pkg::SEL_SQUARE;
        if (status_i.mul_done) begin
          cmd_o.wr_base   = 1'b1;
          cmd_o.shift_exp = 1'b1;
          state_d         = ST_STEP;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // an accepted transaction always starts the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_START))
    else $error("accepted transaction did not start");
  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result overwritten while stalled");
  // leaving finish always raises output valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && out_free) |=> out_valid_q)
    else $error("finished without a result");
`endif

endmodule

`default_nettype wire

FILE: bench/modular_exponentiation_tb.sv
`timescale 1ns / 100ps

module modular_exponentiation_tb;

  localparam int RandomItems = 270;
  localparam int MaxGap      = 18;
  localparam int LongHold    = 4000;
  localparam int HoldAtCount = 30;
  localparam int PauseAt     = 150;
  localparam int DrainCycles = 2500;

  typedef logic [mexp_pkg::DataW-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  bad;
  } power_t;

  typedef struct packed {
    word_t  base;
    word_t  expo;
    word_t  modv;
    logic   typed;
    power_t want;
  } dir_row_t;

  localparam int DirRows = 20;

  // directed rows: typed results only where they are obvious
  localparam dir_row_t DirTable [DirRows] = '{
    // zero modulus flags an error, whatever the exponent
    '{32'd5,        32'd3,        32'd0,        1'b1, '{32'd0, 1'b1}},
    '{32'd5,        32'd0,        32'd0,        1'b1, '{32'd0, 1'b1}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,        1'b1, '{32'd0, 1'b1}},
    // zero exponent gives one, not reduced
    '{32'd7,        32'd0,        32'd1,        1'b1, '{32'd1, 1'b0}},
    '{32'hFFFFFFFF, 32'd0,        32'hFFFFFFFF, 1'b1, '{32'd1, 1'b0}},
    '{32'd0,        32'd0,        32'd5,        1'b1, '{32'd1, 1'b0}},
    // small values
    '{32'd0,        32'd5,        32'd13,       1'b1, '{32'd0, 1'b0}},
    '{32'd100,      32'd9,        32'd1,        1'b1, '{32'd0, 1'b0}},
    '{32'd2,        32'd10,       32'd1000000,  1'b1, '{32'd1024, 1'b0}},
    '{32'd3,        32'd4,        32'd100,      1'b1, '{32'd81, 1'b0}},
    '{32'd5,        32'd1,        32'd7,        1'b1, '{32'd5, 1'b0}},
    '{32'd10,       32'd1,        32'd7,        1'b1, '{32'd3, 1'b0}},
    // extremes of the fields
    '{32'd1,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'd1, 1'b0}},
    '{32'hFFFFFFFF, 32'd1,        32'hFFFFFFFF, 1'b1, '{32'd0, 1'b0}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'd0, 1'b0}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b0, '{32'd0, 1'b0}},
    '{32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '{32'd0, 1'b0}},
    '{32'h12345678, 32'h80000000, 32'hFFFFFFFB, 1'b0, '{32'd0, 1'b0}},
    '{32'hAAAAAAAA, 32'h55555555, 32'h80000000, 1'b0, '{32'd0, 1'b0}},
    '{32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF, 1'b0, '{32'd0, 1'b0}}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid;
  logic  in_stall_o;
  word_t base_value;
  word_t exponent;
  word_t modulus;
  logic  out_valid_o;
  logic  out_stall;
  word_t power_result_o;
  logic  bad_modulus_o;

  power_t pending_powers [$];
  int     fail_count   = 0;
  int     results_seen = 0;

  modular_exponentiation DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .base_value_i   (base_value),
    .exponent_i     (exponent),
    .modulus_i      (modulus),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .power_result_o (power_result_o),
    .bad_modulus_o  (bad_modulus_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // right-to-left square and multiply on operands cut to the datapath width
  function automatic power_t predict_power(word_t b_in, word_t e_in, word_t m_in);
    logic [63:0] mask;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] acc;
    power_t      res;
    mask = (64'd1 << mexp_pkg::Width) - 64'd1;
    b    = {32'd0, b_in} & mask;
    e    = {32'd0, e_in} & mask;
    m    = {32'd0, m_in} & mask;
    acc  = 64'd1;
    if (m == 64'd0) begin
      res.value = '0;
      res.bad   = 1'b1;
      return res;
    end
    b = b % m;
    while (e != 64'd0) begin
      if (e[0]) begin
        acc = (acc * b) % m;
      end
      e = e >> 1;
      b = (b * b) % m;
    end
    res.value = acc[mexp_pkg::DataW-1:0];
    res.bad   = 1'b0;
    return res;
  endfunction

  // offer one transaction after a gap and record its expected result
  task automatic offer_item(input word_t b, input word_t e, input word_t m,
                            input power_t want, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    base_value <= b;
    exponent   <= e;
    modulus    <= m;
    in_valid   <= 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    pending_powers.push_back(want);
  endtask

  // stop offering until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_powers.size() != 0);
  endtask

  // result side: random stalls, one long hold, field checks
  initial begin : result_sink
    int     hold;
    bit     burst;
    power_t got;
    power_t want;
    out_stall = 1'b0;
    burst     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (results_seen % 20 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (results_seen == HoldAtCount) begin
        hold = LongHold;
      end else if (burst) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, MaxGap);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(negedge clk_i); while (!out_valid_o);
      got.value = power_result_o;
      got.bad   = bad_modulus_o;
      @(posedge clk_i);
      results_seen++;
      if (pending_powers.size() == 0) begin
        $error("unexpected result: power_result %h bad_modulus %b", got.value, got.bad);
        fail_count++;
      end else begin
        want = pending_powers.pop_front();
        if (got.value !== want.value) begin
          $error("power_result mismatch: expected %h, actual %h", want.value, got.value);
          fail_count++;
        end
        if (got.bad !== want.bad) begin
          $error("bad_modulus mismatch: expected %b, actual %b", want.bad, got.bad);
          fail_count++;
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : item_source
    int     gap;
    bit     burst;
    word_t  b;
    word_t  e;
    word_t  m;
    power_t want;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    base_value = '0;
    exponent   = '0;
    modulus    = '0;
    burst      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DirRows; i++) begin
      if (DirTable[i].typed) begin
        want = DirTable[i].want;
      end else begin
        want = predict_power(DirTable[i].base, DirTable[i].expo, DirTable[i].modv);
      end
      offer_item(DirTable[i].base, DirTable[i].expo, DirTable[i].modv, want,
                 $urandom_range(0, MaxGap));
    end
    wait_drained();

    // random items, mostly short exponents so the run stays fast
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 16 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (i == PauseAt) begin
        wait_drained();
      end
      case ($urandom_range(0, 15))
        0:       m = '0;
        1:       m = 32'd1;
        2:       m = 32'hFFFFFFFF;
        3, 4:    m = $urandom_range(2, 1000);
        default: m = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       e = '0;
        1, 2:    e = $urandom;
        default: e = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = 32'hFFFFFFFF;
        2:       b = m - 32'd1;
        default: b = $urandom;
      endcase
      gap = burst ? 0 : $urandom_range(0, MaxGap);
      offer_item(b, e, m, predict_power(b, e, m), gap);
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #40_000_000;
    $display("[modular_exponentiation] ERROR");
    $finish;
  end

endmodule
